/* src/dts_pkg.sv */
// Package with shared constants and controller/datapath interface types for the DFS sorter.
package dts_pkg;

  // Default graph dimensions.
  localparam int NUM_VERTICES_DEF  = 8;
  localparam int MAX_OUT_EDGES_DEF = 8;

  // Width of the vertex fields on the item ports.
  localparam int VERT_W = 3;

  // Item operations.
  localparam logic OP_ADD_EDGE = 1'b0;
  localparam logic OP_SORT     = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;      // Latch input fields and read the source list length.
    logic clr;         // Clear visited marks and walk counters for a new sort.
    logic add_wr;      // Append the edge if allowed and load the add result.
    logic s_inc;       // Skip an already visited start vertex.
    logic start;       // Begin a walk at the current start vertex.
    logic edge_rd;     // Read the next neighbor of the top vertex.
    logic push;        // Push the fetched neighbor on the walk stack.
    logic finish;      // Record the top vertex as finished and pop it.
    logic pop;         // Load the new top entry from the stack read data.
    logic emit_start;  // Point the emit counter at the last finished vertex.
    logic emit_rd;     // Read the finish stack at the emit counter.
    logic emit_ld;     // Load one sort result into the output register.
  } dts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic s_end;       // Every start vertex has been considered.
    logic s_vis;       // Current start vertex is already visited.
    logic has_edge;    // Top vertex still has unread neighbors.
    logic can_push;    // Fetched neighbor is in range and unvisited.
    logic last_pop;    // Walk stack holds only the top entry.
    logic emit_last;   // Emit counter is at the final result.
    logic out_free;    // Output register can take a new result.
  } dts_stat_t;

endpackage

/* src/dfs_topological_sort_unit.sv */
// Top level of the depth-first topological sorter: controller plus datapath.
//
// An add-edge item (op 0) gives its single result once the registered read of
// the source list length is back and the output register is free. A sort item
// (op 1) clears the visited marks, walks the graph and then emits NUM_VERTICES
// results in reverse postorder, the last one flagged. In the walk each stored
// edge costs a compare and a registered adjacency memory read, and each
// finished vertex below a root costs a registered walk stack read; each emitted
// result costs a registered finish stack read. Only one item is in progress at
// a time; a result waits in an output register while the next item is taken.
module dfs_topological_sort_unit #(
  parameter int NUM_VERTICES  = dts_pkg::NUM_VERTICES_DEF,
  parameter int MAX_OUT_EDGES = dts_pkg::MAX_OUT_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [dts_pkg::VERT_W-1:0] in_src_vertex,
  input  logic [dts_pkg::VERT_W-1:0] in_dst_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dts_pkg::VERT_W-1:0] out_vertex,
  output logic                       out_last,
  output logic                       out_status
);
  import dts_pkg::*;

  dts_cmd_t  cmd;
  dts_stat_t stat;

  // Sequencer.
  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and result register.
  dts_dpath #(
    .NUM_VERTICES  (NUM_VERTICES),
    .MAX_OUT_EDGES (MAX_OUT_EDGES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_vertex    (out_vertex),
    .out_last      (out_last),
    .out_status    (out_status)
  );

endmodule

/* src/dts_ctrl.sv */
// Controller state machine that sequences edge inserts, the depth-first walk and emission.
module dts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  dts_pkg::dts_stat_t stat,
  output dts_pkg::dts_cmd_t  cmd
);
  import dts_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ADD   = 4'd1;
  localparam logic [3:0] ST_SEL   = 4'd2;
  localparam logic [3:0] ST_CMP   = 4'd3;
  localparam logic [3:0] ST_NB    = 4'd4;
  localparam logic [3:0] ST_POP   = 4'd5;
  localparam logic [3:0] ST_EM_RD = 4'd6;
  localparam logic [3:0] ST_EM_WR = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // New items are taken only while nothing else is in progress.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          if (in_op == OP_ADD_EDGE) begin
            state_nxt = ST_ADD;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = ST_SEL;
          end
        end
      end
      ST_ADD: begin
        if (stat.out_free) begin
          cmd.add_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SEL: begin
        priority if (stat.s_end) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_EM_RD;
        end else if (stat.s_vis) begin
          cmd.s_inc = 1'b1;
        end else begin
          cmd.start = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.has_edge) begin
          cmd.edge_rd = 1'b1;
          state_nxt   = ST_NB;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = stat.last_pop ? ST_SEL : ST_POP;
        end
      end
      ST_NB: begin
        cmd.push  = stat.can_push;
        state_nxt = ST_CMP;
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_EM_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = ST_EM_WR;
      end
      ST_EM_WR: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_nxt   = stat.emit_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/dts_dpath.sv */
// Datapath with the adjacency, count, walk and finish memories and the output register.
module dts_dpath #(
  parameter int NUM_VERTICES  = dts_pkg::NUM_VERTICES_DEF,
  parameter int MAX_OUT_EDGES = dts_pkg::MAX_OUT_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dts_pkg::dts_cmd_t          cmd,
  output dts_pkg::dts_stat_t         stat,
  input  logic [dts_pkg::VERT_W-1:0] in_src_vertex,
  input  logic [dts_pkg::VERT_W-1:0] in_dst_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dts_pkg::VERT_W-1:0] out_vertex,
  output logic                       out_last,
  output logic                       out_status
);
  import dts_pkg::*;

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int DW = VW + 1;
  localparam int CW = $clog2(MAX_OUT_EDGES + 1);
  localparam int AW = $clog2(NUM_VERTICES * MAX_OUT_EDGES);
  localparam int SW = VW + CW;
  localparam int NE = NUM_VERTICES * MAX_OUT_EDGES;

  // Captured input fields.
  logic [VERT_W-1:0] src_r;
  logic [VERT_W-1:0] dst_r;

  // Adjacency lists, one row of MAX_OUT_EDGES per vertex.
  logic [VW-1:0] adj_mem_r [NE];
  logic [VW-1:0] adj_q_r;

  // List lengths with per-entry valid bits; an invalid entry reads as zero.
  logic [CW-1:0]           cnt_mem_r [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] cnt_vld_r;
  logic [CW-1:0]           cnt_q_r;
  logic                    cnt_qv_r;
  logic [CW-1:0]           cnt;

  // Visited marks.
  logic [NUM_VERTICES-1:0] vis_r;

  // Walk stack below the top entry, plus the top entry in registers.
  logic [SW-1:0] stk_mem_r [NUM_VERTICES];
  logic [SW-1:0] stk_q_r;
  logic [VW-1:0] top_v_r;
  logic [CW-1:0] top_n_r;
  logic [DW-1:0] depth_r;

  // Finish stack and walk counters.
  logic [VW-1:0] fin_mem_r [NUM_VERTICES];
  logic [VW-1:0] fin_q_r;
  logic [DW-1:0] s_r;
  logic [DW-1:0] done_r;
  logic [VW-1:0] e_r;

  // Output register.
  logic              out_valid_r;
  logic [VERT_W-1:0] out_vertex_r;
  logic              out_last_r;
  logic              out_status_r;

  logic          cnt_re;
  logic [VW-1:0] cnt_ra;
  logic          add_ok;
  logic [AW-1:0] add_wa;
  logic [AW-1:0] edge_ra;
  logic          w_ok;

  assign cnt = cnt_qv_r ? cnt_q_r : '0;

  // Edge insert checks and addresses.
  always_comb begin
    add_ok  = (int'(src_r) < NUM_VERTICES) && (int'(dst_r) < NUM_VERTICES) &&
              (cnt < CW'(MAX_OUT_EDGES));
    add_wa  = AW'(AW'(VW'(src_r)) * AW'(MAX_OUT_EDGES) + AW'(cnt));
    edge_ra = AW'(AW'(top_v_r) * AW'(MAX_OUT_EDGES) + AW'(top_n_r));
    w_ok    = int'(adj_q_r) < NUM_VERTICES;
  end

  // Address of the list length read.
  always_comb begin
    cnt_re = cmd.cap_in | cmd.start | cmd.push | cmd.pop;
    priority if (cmd.cap_in) begin
      cnt_ra = VW'(in_src_vertex);
    end else if (cmd.start) begin
      cnt_ra = VW'(s_r);
    end else if (cmd.push) begin
      cnt_ra = adj_q_r;
    end else begin
      cnt_ra = stk_q_r[SW-1:CW];
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.s_end     = (s_r == DW'(NUM_VERTICES));
    stat.s_vis     = vis_r[VW'(s_r)];
    stat.has_edge  = (top_n_r < cnt);
    stat.can_push  = w_ok && !vis_r[adj_q_r] && (int'(depth_r) < NUM_VERTICES);
    stat.last_pop  = (depth_r == DW'(1));
    stat.emit_last = (e_r == '0);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      src_r <= in_src_vertex;
      dst_r <= in_dst_vertex;
    end
  end

  // Adjacency memory: one write port for inserts, one registered read for the walk.
  always_ff @(posedge clk) begin
    if (cmd.add_wr && add_ok) begin
      adj_mem_r[add_wa] <= VW'(dst_r);
    end
    if (cmd.edge_rd) begin
      adj_q_r <= adj_mem_r[edge_ra];
    end
  end

  // List length memory.
  always_ff @(posedge clk) begin
    if (cmd.add_wr && add_ok) begin
      cnt_mem_r[VW'(src_r)] <= cnt + CW'(1);
    end
    if (cnt_re) begin
      cnt_q_r <= cnt_mem_r[cnt_ra];
    end
  end

  // List length valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      cnt_qv_r  <= 1'b0;
    end else begin
      if (cmd.add_wr && add_ok) begin
        cnt_vld_r[VW'(src_r)] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_qv_r <= cnt_vld_r[cnt_ra];
      end
    end
  end

  // Visited marks and start vertex scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
    end else if (cmd.clr) begin
      vis_r <= '0;
    end else if (cmd.start) begin
      vis_r[VW'(s_r)] <= 1'b1;
    end else if (cmd.push) begin
      vis_r[adj_q_r] <= 1'b1;
    end
  end

  // Walk stack memory: the old top is written on a push, the next top read on a finish.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem_r[VW'(depth_r - DW'(1))] <= {top_v_r, top_n_r};
    end
    if (cmd.finish && (depth_r > DW'(1))) begin
      stk_q_r <= stk_mem_r[VW'(depth_r - DW'(2))];
    end
  end

  // Top entry, depth and walk counters.
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      s_r    <= '0;
      done_r <= '0;
    end
    if (cmd.s_inc || cmd.start) begin
      s_r <= s_r + DW'(1);
    end
    if (cmd.start) begin
      top_v_r <= VW'(s_r);
      top_n_r <= '0;
      depth_r <= DW'(1);
    end
    if (cmd.edge_rd) begin
      top_n_r <= top_n_r + CW'(1);
    end
    if (cmd.push) begin
      top_v_r <= adj_q_r;
      top_n_r <= '0;
      depth_r <= depth_r + DW'(1);
    end
    if (cmd.finish) begin
      depth_r <= depth_r - DW'(1);
      if (int'(done_r) < NUM_VERTICES) begin
        done_r <= done_r + DW'(1);
      end
    end
    if (cmd.pop) begin
      top_v_r <= stk_q_r[SW-1:CW];
      top_n_r <= stk_q_r[CW-1:0];
    end
    if (cmd.emit_start) begin
      e_r <= VW'(done_r - DW'(1));
    end
    if (cmd.emit_ld) begin
      e_r <= e_r - VW'(1);
    end
  end

  // Finish stack memory.
  always_ff @(posedge clk) begin
    if (cmd.finish && (int'(done_r) < NUM_VERTICES)) begin
      fin_mem_r[VW'(done_r)] <= top_v_r;
    end
    if (cmd.emit_rd) begin
      fin_q_r <= fin_mem_r[e_r];
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.add_wr || cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      out_vertex_r <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= add_ok ? STATUS_OK : STATUS_DROPPED;
    end else if (cmd.emit_ld) begin
      out_vertex_r <= VERT_W'(fin_q_r);
      out_last_r   <= (e_r == '0);
      out_status_r <= STATUS_OK;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

/* src/dts_checker.sv */
// Port-level checker for the sorter, bound to the top level.
module dts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [dts_pkg::VERT_W-1:0] out_vertex,
  input logic                       out_last,
  input logic                       out_status
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex) && $stable(out_last))
    else $error("stalled result changed or vanished");

  // Only one item is in progress, so the input stalls right after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in progress");

  // A dropped edge comes only as the single result of an add item.
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && (out_vertex == '0))
    else $error("drop status on a malformed result");

  // Results before the last one belong to a sort and carry no status.
  a_sort_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_status)
    else $error("status set on a sort result");

endmodule

bind dfs_topological_sort_unit dts_checker u_dts_checker (.*);

/* dv/tb_dfs_topological_sort_unit.sv */
// Self-checking testbench for the depth-first topological sorter, with its own graph predictor.
module tb_dfs_topological_sort_unit;
  import dts_pkg::*;

  localparam int NV = NUM_VERTICES_DEF;
  localparam int ME = MAX_OUT_EDGES_DEF;

  // Run limits, in clock cycles.
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [VERT_W-1:0] vertex;
    logic              last;
    logic              status;
  } vertex_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [VERT_W-1:0] in_src_vertex;
  logic [VERT_W-1:0] in_dst_vertex;
  logic              out_valid;
  logic              out_stall;
  logic [VERT_W-1:0] out_vertex;
  logic              out_last;
  logic              out_status;

  // Predicted graph: adjacency lists in insertion order and their lengths.
  logic [VERT_W-1:0] adj_dst [NV][ME];
  logic [3:0]        adj_len [NV];

  vertex_result_t results_due[$];

  bit in_idle_on    = 1'b1;
  bit stall_idle_on = 1'b1;
  bit hold_req      = 1'b0;

  int fail_count    = 0;
  int edges_added   = 0;
  int edges_dropped = 0;
  int sorts_run     = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;

  dfs_topological_sort_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_vertex    (out_vertex),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append one predicted result at the tail of the queue.
  function automatic void add_prediction(input vertex_result_t r);
    results_due = {results_due, r};
  endfunction

  // Append an edge to the predicted graph and queue its single result.
  function automatic void apply_edge(input logic [VERT_W-1:0] src, input logic [VERT_W-1:0] dst);
    vertex_result_t r;
    r.vertex = '0;
    r.last   = 1'b1;
    r.status = STATUS_DROPPED;
    if (int'(src) < NV && int'(dst) < NV && adj_len[src] < ME) begin
      adj_dst[src][adj_len[src]] = dst;
      adj_len[src] = adj_len[src] + 4'd1;
      r.status = STATUS_OK;
      edges_added++;
    end else begin
      edges_dropped++;
    end
    add_prediction(r);
  endfunction

  // Iterative depth-first walk over the predicted graph; queue reverse postorder.
  function automatic void compute_topo_order();
    logic              seen    [NV];
    logic [VERT_W-1:0] walk_v  [NV];
    logic [3:0]        walk_ix [NV];
    logic [VERT_W-1:0] post    [NV];
    logic [VERT_W-1:0] v;
    logic [VERT_W-1:0] w;
    int                depth;
    int                done;
    vertex_result_t    r;
    done = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    for (int s = 0; s < NV; s++) begin
      if (!seen[s]) begin
        seen[s]    = 1'b1;
        walk_v[0]  = VERT_W'(s);
        walk_ix[0] = '0;
        depth      = 1;
        while (depth > 0) begin
          v = walk_v[depth-1];
          if (walk_ix[depth-1] < adj_len[v]) begin
            w = adj_dst[v][walk_ix[depth-1]];
            walk_ix[depth-1] = walk_ix[depth-1] + 4'd1;
            // Visited neighbors, self loops among them, are passed over.
            if (int'(w) < NV && !seen[w] && depth < NV) begin
              seen[w]        = 1'b1;
              walk_v[depth]  = w;
              walk_ix[depth] = '0;
              depth++;
            end
          end else begin
            if (done < NV) begin
              post[done] = v;
              done++;
            end
            depth--;
          end
        end
      end
    end
    for (int k = 0; k < done; k++) begin
      r.vertex = post[done-1-k];
      r.last   = (k == done - 1);
      r.status = STATUS_OK;
      add_prediction(r);
    end
    sorts_run++;
  endfunction

  // Offer one item after an optional gap, wait for acceptance, then predict it.
  task automatic send_item(input logic op, input logic [VERT_W-1:0] src,
                           input logic [VERT_W-1:0] dst);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_src_vertex <= src;
    in_dst_vertex <= dst;
    do @(posedge clk); while (in_stall);
    if (op == OP_ADD_EDGE) apply_edge(src, dst);
    else compute_topo_order();
  endtask

  // Empty-graph sort, extreme vertices, self loops, duplicates and a cycle.
  task automatic test_extremes_and_cycles();
    send_item(OP_SORT, 3'd0, 3'd0);
    send_item(OP_ADD_EDGE, 3'd0, 3'd0);
    send_item(OP_ADD_EDGE, 3'd7, 3'd7);
    send_item(OP_ADD_EDGE, 3'd0, 3'd7);
    send_item(OP_ADD_EDGE, 3'd7, 3'd0);
    send_item(OP_ADD_EDGE, 3'd0, 3'd7);
    send_item(OP_ADD_EDGE, 3'd3, 3'd5);
    send_item(OP_ADD_EDGE, 3'd5, 3'd3);
    send_item(OP_SORT, 3'd7, 3'd7);
  endtask

  // Fill one adjacency list, then push one more edge that must be dropped.
  task automatic test_full_list();
    for (int i = 0; i < ME; i++) send_item(OP_ADD_EDGE, 3'd2, VERT_W'(i));
    send_item(OP_ADD_EDGE, 3'd2, 3'd4);
    send_item(OP_SORT, 3'd5, 3'd2);
  endtask

  // Random edges and sorts; the first half leans toward forward edges.
  task automatic test_random_mix(input int n_items);
    logic [VERT_W-1:0] s;
    logic [VERT_W-1:0] d;
    for (int i = 0; i < n_items; i++) begin
      s = VERT_W'($urandom_range(0, NV - 1));
      d = VERT_W'($urandom_range(0, NV - 1));
      if ($urandom_range(0, 5) == 0) begin
        send_item(OP_SORT, s, d);
      end else begin
        if (i < n_items / 2 && int'(s) < NV - 1 && $urandom_range(0, 3) != 0)
          d = VERT_W'($urandom_range(int'(s) + 1, NV - 1));
        send_item(OP_ADD_EDGE, s, d);
      end
    end
  endtask

  // Full rate on both sides, no gaps and no stalls.
  task automatic test_back_to_back(input int n_items);
    in_idle_on    = 1'b0;
    stall_idle_on = 1'b0;
    for (int i = 0; i < n_items; i++)
      send_item(($urandom_range(0, 4) == 0) ? OP_SORT : OP_ADD_EDGE,
                VERT_W'($urandom_range(0, NV - 1)), VERT_W'($urandom_range(0, NV - 1)));
    in_idle_on    = 1'b1;
    stall_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure(input int n_items);
    in_idle_on = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < n_items; i++)
      send_item((i % 7 == 3) ? OP_SORT : OP_ADD_EDGE,
                VERT_W'($urandom_range(0, NV - 1)), VERT_W'($urandom_range(0, NV - 1)));
    in_idle_on = 1'b1;
  endtask

  // Result-side stall generator; the long hold is counted down here.
  initial begin : result_stall_gen
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stall_idle_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  initial begin : result_checker
    vertex_result_t e;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("unexpected result: vertex %0d last %0b status %0b",
                 out_vertex, out_last, out_status);
          fail_count++;
        end else begin
          e = results_due.pop_front();
          if (out_vertex !== e.vertex) begin
            $error("vertex mismatch: expected %0d, actual %0d", e.vertex, out_vertex);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last mismatch: expected %0b, actual %0b", e.last, out_last);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status mismatch: expected %0b, actual %0b", e.status, out_status);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any accepted item or result.
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog expired with %0d results still expected.", results_due.size());
    $display("FAIL dfs_topological_sort_unit");
    $finish;
  end

  // Main sequence: reset, the tests in turn, drain and verdict.
  initial begin : main_seq
    foreach (adj_len[i]) adj_len[i] = '0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_ADD_EDGE;
    in_src_vertex <= '0;
    in_dst_vertex <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes_and_cycles();
    test_full_list();
    test_random_mix(300);
    test_back_to_back(30);
    test_backpressure(20);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stored edges, %0d dropped edges and %0d sorts,", edges_added,
             edges_dropped, sorts_run);
    $display("with %0d results checked under random gaps, full rate and a long hold-off.",
             results_seen);
    if (fail_count == 0) begin
      $display("PASS dfs_topological_sort_unit");
    end else begin
      $display("FAIL dfs_topological_sort_unit");
    end
    $finish;
  end

endmodule
